[rtl/jet_pkg.sv]
// ----------------------------------------------------------------------------
// jet_pkg: shared types and constants
// Fixed-point widths, register indexes and the record passed from cell to cell.
// ----------------------------------------------------------------------------
package jet_pkg;

	localparam int IterLimit = 64;
	localparam int CellCount = IterLimit + 1;
	localparam int FracBits = 28;

	localparam logic [2:0] REG_C_RE      = 3'd0;
	localparam logic [2:0] REG_C_IM      = 3'd1;
	localparam logic [2:0] REG_ORIGIN_RE = 3'd2;
	localparam logic [2:0] REG_ORIGIN_IM = 3'd3;
	localparam logic [2:0] REG_STEP      = 3'd4;
	localparam logic [2:0] REG_MAX_ITER  = 3'd5;

	localparam logic [64:0] ESC_BOUND = 65'd1 << (2 * FracBits + 2);

	typedef struct packed {
		logic               done;
		logic [6:0]         iters;
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic [9:0]         col;
		logic [9:0]         row;
	} jet_item_t;

	function automatic logic fits_q38(input logic signed [37:0] v);
		return v[37:31] == {7{v[31]}};
	endfunction

	function automatic logic fits_q43(input logic signed [42:0] v);
		return v[42:31] == {12{v[31]}};
	endfunction

endpackage

[rtl/jet_if.sv]
// ----------------------------------------------------------------------------
// jet_if: channel interfaces
// Pixel request, result and register write channels.
// ----------------------------------------------------------------------------
interface jet_pix_if;
	logic       valid;
	logic       ready;
	logic [9:0] col;
	logic [9:0] row;
	modport source (output valid, col, row, input ready);
	modport sink (input valid, col, row, output ready);
endinterface

interface jet_res_if;
	logic       valid;
	logic       ready;
	logic [9:0] out_col;
	logic [9:0] out_row;
	logic [6:0] iterations;
	logic       escaped;
	modport source (output valid, out_col, out_row, iterations, escaped, input ready);
	modport sink (input valid, out_col, out_row, iterations, escaped, output ready);
endinterface

interface jet_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/jet_front.sv]
// ----------------------------------------------------------------------------
// jet_front: start point
// Maps a pixel to z0 and flags a start point outside the Q4.28 range.
// ----------------------------------------------------------------------------
module jet_front import jet_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [9:0]         col,
	input  logic [9:0]         row,
	input  logic signed [31:0] origin_re,
	input  logic signed [31:0] origin_im,
	input  logic [30:0]        step,
	input  logic [6:0]         n,
	output logic               out_valid_s1,
	output jet_item_t          out_s1
);

	logic [40:0]        col_off;
	logic [40:0]        row_off;
	logic signed [42:0] re0;
	logic signed [42:0] im0;
	logic               out_of_range;

	assign col_off = 41'(col) * 41'(step);
	assign row_off = 41'(row) * 41'(step);
	assign re0 = 43'(origin_re) + $signed({2'b00, col_off});
	assign im0 = 43'(origin_im) + $signed({2'b00, row_off});
	assign out_of_range = !fits_q43(re0) || !fits_q43(im0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (en) begin
			out_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s1.done  <= out_of_range && (n != 7'd0);
			out_s1.iters <= (out_of_range && (n != 7'd0)) ? 7'd1 : 7'd0;
			out_s1.re    <= re0[31:0];
			out_s1.im    <= im0[31:0];
			out_s1.col   <= col;
			out_s1.row   <= row;
		end
	end

endmodule

[rtl/jet_cell.sv]
// ----------------------------------------------------------------------------
// jet_cell: one iteration
// Squares z, tests the escape bound and forms the next z = z*z + c.
// ----------------------------------------------------------------------------
module jet_cell import jet_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [6:0]         idx,
	input  logic signed [31:0] c_re,
	input  logic signed [31:0] c_im,
	input  logic [6:0]         n,
	input  logic               in_valid,
	input  jet_item_t          in_item,
	output logic               out_valid_s2,
	output jet_item_t          out_s2
);

	logic               valid_s1;
	jet_item_t          item_s1;
	logic signed [63:0] sq_re_s1;
	logic signed [63:0] sq_im_s1;
	logic signed [63:0] prod_s1;

	logic [64:0]        mag;
	logic signed [64:0] diff;
	logic signed [37:0] nr;
	logic signed [37:0] ni;
	logic               mag_esc;
	logic               may_step;
	logic               range_esc;
	jet_item_t          nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1     <= in_valid;
			out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1  <= in_item;
			sq_re_s1 <= in_item.re * in_item.re;
			sq_im_s1 <= in_item.im * in_item.im;
			prod_s1  <= in_item.re * in_item.im;
		end
	end

	assign mag = {1'b0, sq_re_s1} + {1'b0, sq_im_s1};
	assign diff = 65'(sq_re_s1) - 65'(sq_im_s1);
	assign nr = 38'($signed(diff[64:FracBits])) + 38'(c_re);
	assign ni = 38'($signed(prod_s1[63:FracBits-1])) + 38'(c_im);
	assign mag_esc = !item_s1.done && (idx != 7'd0) && (idx <= n) && (mag > ESC_BOUND);
	assign may_step = !item_s1.done && !mag_esc && (idx < n);
	assign range_esc = may_step && (!fits_q38(nr) || !fits_q38(ni));

	always_comb begin
		nxt = item_s1;
		if (mag_esc) begin
			nxt.done  = 1'b1;
			nxt.iters = idx;
		end else if (range_esc) begin
			nxt.done  = 1'b1;
			nxt.iters = idx + 7'd1;
		end else if (may_step) begin
			nxt.re = nr[31:0];
			nxt.im = ni[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s2 <= nxt;
		end
	end

endmodule

[rtl/julia_escape_time.sv]
// ----------------------------------------------------------------------------
// julia_escape_time: Julia set escape-time pixel engine
// Start stage followed by a chain of iteration cells.
// ----------------------------------------------------------------------------
// Usage:
//   pix  : pixel requests (col, row), accepted when valid and ready are high.
//   res  : one result per request, in order: position, escape iteration
//          (1..max_iter, capped at 64, 0 if none) and the escaped flag.
//   cfg  : register writes (index, data), always ready; write only while idle.
// A request passes one start stage and 65 cells of two stages each; the
// last cell register is the output register.
// Throughput is one pixel per cycle unless the receiver stalls; each cell holds
// one iteration of a different pixel, so the count of cells sets the latency, not the rate.
// Reset clears all valid bits and loads the register defaults.
// When the receiver stalls, the whole chain holds and pix.ready drops.
// ----------------------------------------------------------------------------
module julia_escape_time import jet_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	jet_pix_if.sink   pix,
	jet_res_if.source res,
	jet_cfg_if.sink   cfg
);

	logic signed [31:0] c_re_q;
	logic signed [31:0] c_im_q;
	logic signed [31:0] origin_re_q;
	logic signed [31:0] origin_im_q;
	logic [30:0]        step_q;
	logic [6:0]         max_iter_q;
	logic [6:0]         n;
	logic               en;

	logic      valid_c [CellCount+1];
	jet_item_t item_c  [CellCount+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_re_q      <= 32'sd0;
			c_im_q      <= 32'sd0;
			origin_re_q <= -32'sd536870912;
			origin_im_q <= -32'sd536870912;
			step_q      <= 31'd1048576;
			max_iter_q  <= 7'd50;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_C_RE:      c_re_q      <= cfg.data;
				REG_C_IM:      c_im_q      <= cfg.data;
				REG_ORIGIN_RE: origin_re_q <= cfg.data;
				REG_ORIGIN_IM: origin_im_q <= cfg.data;
				REG_STEP:      step_q      <= cfg.data[30:0];
				REG_MAX_ITER:  max_iter_q  <= cfg.data[6:0];
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;
	assign n = (max_iter_q > 7'(IterLimit)) ? 7'(IterLimit) : max_iter_q;
	assign en = !valid_c[CellCount] || res.ready;
	assign pix.ready = en;

	jet_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(pix.valid), .col(pix.col), .row(pix.row),
		.origin_re(origin_re_q), .origin_im(origin_im_q), .step(step_q), .n(n),
		.out_valid_s1(valid_c[0]), .out_s1(item_c[0])
	);

	for (genvar g = 0; g < CellCount; g++) begin : g_cell
		jet_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .idx(7'(g)),
			.c_re(c_re_q), .c_im(c_im_q), .n(n),
			.in_valid(valid_c[g]), .in_item(item_c[g]),
			.out_valid_s2(valid_c[g+1]), .out_s2(item_c[g+1])
		);
	end

	assign res.valid      = valid_c[CellCount];
	assign res.out_col    = item_c[CellCount].col;
	assign res.out_row    = item_c[CellCount].row;
	assign res.iterations = item_c[CellCount].iters;
	assign res.escaped    = item_c[CellCount].iters != 7'd0;

endmodule

[rtl/jet_checker.sv]
// ----------------------------------------------------------------------------
// jet_checker: port checks
// Result channel properties seen at the top level ports.
// ----------------------------------------------------------------------------
module jet_checker import jet_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       pix_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [9:0] res_col,
	input logic [9:0] res_row,
	input logic [6:0] res_iters,
	input logic       res_escaped
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_col) && $stable(res_row))
		else $error("result dropped while stalled");

	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_escaped == (res_iters != 7'd0))
		else $error("escaped flag disagrees with count");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_iters <= 7'(IterLimit))
		else $error("iteration count above limit");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !pix_ready)
		else $error("request taken while result stalled");

endmodule

bind julia_escape_time jet_checker u_jet_checker (
	.clk(clk), .arst_n(arst_n), .pix_ready(pix.ready),
	.res_valid(res.valid), .res_ready(res.ready),
	.res_col(res.out_col), .res_row(res.out_row),
	.res_iters(res.iterations), .res_escaped(res.escaped)
);

[bench/tb_if_note.sv]
// ----------------------------------------------------------------------------
// tb_support: shared bench types
// Request and result records used by the escape-time bench queues.
// ----------------------------------------------------------------------------
package tb_support_pkg;

	typedef struct packed {
		logic [9:0] col;
		logic [9:0] row;
	} pix_req_t;

	typedef struct packed {
		logic [9:0] col;
		logic [9:0] row;
		logic [6:0] iters;
		logic       esc;
	} pix_res_t;

endpackage

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: escape-time engine regression
// Drives pixel requests and register writes, predicts escape counts with an
// exact integer model, and checks every result in order under random stalls.
// ----------------------------------------------------------------------------
module tb;
	import jet_pkg::*;
	import tb_support_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	jet_pix_if pix ();
	jet_res_if res ();
	jet_cfg_if cfg ();

	julia_escape_time u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.res    (res),
		.cfg    (cfg)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic signed [31:0] k_c_re, k_c_im, k_org_re, k_org_im;
	logic [30:0]        k_step;
	logic [6:0]         k_max_iter;

	pix_req_t pend_pix[$];
	pix_res_t want_res[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off_cycles = 0;
	int bad_count = 0;
	int got_count = 0;
	int sent_count = 0;
	int esc_count = 0;

	function automatic logic signed [63:0] floor_shr(input logic signed [63:0] v, input int n);
		return v >>> n;
	endfunction

	function automatic logic in_q(input logic signed [63:0] v);
		return v >= -64'sd2147483648 && v <= 64'sd2147483647;
	endfunction

	function automatic logic [6:0] escape_iter(input logic [9:0] col, input logic [9:0] row);
		logic signed [63:0] zr, zi, nr, ni;
		logic [63:0] mag;
		int n;
		n = (k_max_iter > IterLimit) ? IterLimit : k_max_iter;
		zr = 64'(k_org_re) + $signed(64'(col) * 64'(k_step));
		zi = 64'(k_org_im) + $signed(64'(row) * 64'(k_step));
		if (n == 0)
			return 7'd0;
		if (!in_q(zr) || !in_q(zi))
			return 7'd1;
		for (int i = 1; i <= n; i++) begin
			nr = floor_shr(zr * zr - zi * zi, FracBits) + 64'(k_c_re);
			ni = floor_shr(zr * zi, FracBits - 1) + 64'(k_c_im);
			if (!in_q(nr) || !in_q(ni))
				return 7'(i);
			mag = 64'(nr * nr) + 64'(ni * ni);
			if (mag > (64'd1 << 58))
				return 7'(i);
			zr = nr;
			zi = ni;
		end
		return 7'd0;
	endfunction

	task automatic queue_pixel(input logic [9:0] col, input logic [9:0] row);
		pix_req_t p;
		p.col = col;
		p.row = row;
		pend_pix.push_back(p);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		pix_res_t r;
		if (!arst_n) begin
			pix.valid <= 1'b0;
			pix.col <= '0;
			pix.row <= '0;
		end else begin
			if (pix.valid && pix.ready) begin
				r.col = pix.col;
				r.row = pix.row;
				r.iters = escape_iter(pix.col, pix.row);
				r.esc = r.iters != 0;
				want_res.push_back(r);
				void'(pend_pix.pop_front());
				sent_count++;
			end
			if ((!pix.valid || pix.ready) && pend_pix.size() > 0 &&
			    !(pix.valid && pix.ready && pend_pix.size() == 0)) begin
				if ($urandom_range(99) >= send_idle_pct) begin
					pix.valid <= 1'b1;
					pix.col <= pend_pix[0].col;
					pix.row <= pend_pix[0].row;
				end else begin
					pix.valid <= 1'b0;
				end
			end else if (!pix.valid || pix.ready) begin
				pix.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		pix_res_t w;
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				got_count++;
				if (want_res.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("unexpected result col=%0d row=%0d", res.out_col, res.out_row);
				end else begin
					w = want_res.pop_front();
					if (res.escaped)
						esc_count++;
					if (res.out_col !== w.col || res.out_row !== w.row ||
					    res.iterations !== w.iters || res.escaped !== w.esc) begin
						bad_count++;
						if (bad_count <= 10)
							$display("mismatch exp col=%0d row=%0d it=%0d esc=%0d got col=%0d row=%0d it=%0d esc=%0d",
							         w.col, w.row, w.iters, w.esc,
							         res.out_col, res.out_row, res.iterations, res.escaped);
					end
				end
			end
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= $urandom_range(99) >= recv_stall_pct;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		case (idx)
			REG_C_RE:      k_c_re = val;
			REG_C_IM:      k_c_im = val;
			REG_ORIGIN_RE: k_org_re = val;
			REG_ORIGIN_IM: k_org_im = val;
			REG_STEP:      k_step = val[30:0];
			REG_MAX_ITER:  k_max_iter = val[6:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pend_pix.size() > 0 || pix.valid || want_res.size() > 0)
			@(posedge clk);
		repeat (140) @(posedge clk);
	endtask

	task automatic write_all(input logic [31:0] cr, input logic [31:0] ci, input logic [31:0] orr,
	                         input logic [31:0] ori, input logic [31:0] st, input logic [31:0] mi);
		drain();
		write_reg(REG_C_RE, cr);
		write_reg(REG_C_IM, ci);
		write_reg(REG_ORIGIN_RE, orr);
		write_reg(REG_ORIGIN_IM, ori);
		write_reg(REG_STEP, st);
		write_reg(REG_MAX_ITER, mi);
		cfg.valid <= 1'b0;
	endtask

	task automatic random_block(input int count);
		for (int i = 0; i < count; i++)
			queue_pixel($urandom_range(1023), $urandom_range(1023));
	endtask

	initial begin
		k_c_re = 0;
		k_c_im = 0;
		k_org_re = 32'hE000_0000;
		k_org_im = 32'hE000_0000;
		k_step = 31'd1048576;
		k_max_iter = 7'd50;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_pixel(0, 0);
		queue_pixel(1023, 1023);
		queue_pixel(0, 1023);
		queue_pixel(1023, 0);
		queue_pixel(512, 512);
		queue_pixel(10'h2AA, 10'h155);
		queue_pixel(10'h155, 10'h2AA);
		queue_pixel(384, 640);
		drain();

		write_all(32'hF345_6000, 32'h0A3D_70A4, 32'hE000_0000, 32'hE000_0000, 32'd1048576, 64);
		queue_pixel(300, 500);
		queue_pixel(512, 512);
		queue_pixel(700, 200);
		queue_pixel(0, 0);

		write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
		queue_pixel(0, 0);
		queue_pixel(1023, 1023);
		queue_pixel(1, 0);

		write_all(0, 0, 0, 0, 0, 0);
		queue_pixel(5, 5);
		queue_pixel(1023, 1023);

		write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'hF000_0000, 32'hF000_0000, 32'd1, 127);
		queue_pixel(0, 0);
		queue_pixel(1023, 1023);
		queue_pixel(512, 0);

		write_all(32'hF345_6000, 32'h0A3D_70A4, 32'hE000_0000, 32'hE000_0000, 32'd1048576, 64);
		random_block(150);

		send_idle_pct = 54;
		random_block(150);
		drain();
		send_idle_pct = 0;
		recv_stall_pct = 54;
		random_block(150);
		drain();
		send_idle_pct = 36;
		recv_stall_pct = 36;
		random_block(150);

		hold_off_cycles = 400;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_block(250);

		write_all(32'hFCCC_CCCD, 32'h028F_5C29, 32'hE800_0000, 32'hE800_0000, 32'd786432, 20);
		send_idle_pct = 54;
		recv_stall_pct = 54;
		random_block(120);

		write_all($urandom, $urandom, $urandom, $urandom, $urandom_range(2097152), $urandom_range(70));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_block(100);

		drain();
		$display("Covered %0d pixels over several register settings, %0d escaped.",
		         got_count, esc_count);
		if (bad_count == 0 && want_res.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

[filelist.f]
rtl/jet_pkg.sv
rtl/jet_if.sv
rtl/jet_front.sv
rtl/jet_cell.sv
rtl/julia_escape_time.sv
rtl/jet_checker.sv
bench/tb_if_note.sv
bench/tb.sv
